// ===== rtl/hilbert_curve_converter_macros.svh =====
// Assertion macros used by the converter's cell RTL.
`ifndef HILBERT_CURVE_CONVERTER_MACROS_SVH
`define HILBERT_CURVE_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge out of reset.
`define HCC_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hilbert_curve_converter: assertion failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define HCC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hilbert_curve_converter: assertion failed");

`else

`define HCC_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define HCC_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/hcc_pkg.sv =====
package hcc_pkg;

    // Field widths fixed by the interface.
    localparam int COORD_W  = 16;
    localparam int INDEX_W  = 32;
    localparam int CFG_W    = 5;
    localparam int LEVEL_W  = 5;

    // Default level count and the reset value of the side register.
    localparam int              MAX_LEVELS_DEFAULT = 16;
    localparam logic [CFG_W-1:0] GRID_LOG2_RESET    = 5'd8;

    // Direction codes.
    localparam logic KIND_XY_TO_D = 1'b0;
    localparam logic KIND_D_TO_XY = 1'b1;

    // One item as it travels down the row of cells.
    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
        logic [INDEX_W-1:0] src_d;
        logic [COORD_W-1:0] res_x;
        logic [COORD_W-1:0] res_y;
        logic [INDEX_W-1:0] res_d;
        logic               cmp;   // pending complement of the sub-square
        logic               swp;   // pending swap of the sub-square
    } item_t;

endpackage

// ===== rtl/hcc_cell.sv =====
`include "hilbert_curve_converter_macros.svh"

module hcc_cell #(
    parameter int LEVEL = 0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [hcc_pkg::LEVEL_W-1:0]  levels,
    input  logic                         valid_in,
    output logic                         ready_out,
    input  hcc_pkg::item_t               item_in,
    output logic                         valid_out,
    input  logic                         ready_in,
    output hcc_pkg::item_t               item_out
);

    localparam int LEVEL_W = hcc_pkg::LEVEL_W;

    logic           valid_reg;
    hcc_pkg::item_t data_reg;
    hcc_pkg::item_t data_next;
    logic           load;
    logic           level_on;
    logic           xb, yb, a, b, rx, ry;
    logic [1:0]     quad;

    // The stage takes a new transfer when empty or when its content moves on.
    assign ready_out = !valid_reg || ready_in;
    assign load      = valid_in && ready_out;
    assign level_on  = (LEVEL_W'(LEVEL) < levels);

    // Quadrant of this level, with the pending rotation of the sub-square applied.
    always_comb begin
        data_next = item_in;
        xb   = item_in.src_x[LEVEL];
        yb   = item_in.src_y[LEVEL];
        quad = item_in.src_d[2*LEVEL +: 2];
        a    = 1'b0;
        b    = 1'b0;
        rx   = 1'b0;
        ry   = 1'b0;
        if (item_in.kind == hcc_pkg::KIND_XY_TO_D) begin
            // Swap first, then complement, to map grid bits onto the quadrant.
            a  = item_in.swp ? yb : xb;
            b  = item_in.swp ? xb : yb;
            rx = a ^ item_in.cmp;
            ry = b ^ item_in.cmp;
            if (level_on) begin
                data_next.res_d[2*LEVEL +: 2] = {rx, rx ^ ry};
            end
        end else begin
            // Inverse mapping: complement first, then swap.
            rx = quad[1];
            ry = quad[0] ^ quad[1];
            a  = rx ^ item_in.cmp;
            b  = ry ^ item_in.cmp;
            if (level_on) begin
                data_next.res_x[LEVEL] = item_in.swp ? b : a;
                data_next.res_y[LEVEL] = item_in.swp ? a : b;
            end
        end
        // The lower sub-square turns when the quadrant lies in the bottom row.
        if (level_on && !ry) begin
            data_next.cmp = item_in.cmp ^ rx;
            data_next.swp = !item_in.swp;
        end
    end

    // Stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_out) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign item_out  = data_reg;

    // A stalled stage keeps its item.
    `HCC_ASSERT_NEXT(a_hold_on_stall, aclk, aresetn, valid_reg && !ready_in,
        valid_reg && $stable(data_reg))
    // A level beyond the grid leaves the item untouched.
    `HCC_ASSERT_NEXT(a_idle_level_passes, aclk, aresetn, load && !level_on,
        data_reg == $past(item_in))
    // A transfer toward the index never writes coordinates.
    `HCC_ASSERT_NEXT(a_xy_kind_keeps_coords, aclk, aresetn,
        load && (item_in.kind == hcc_pkg::KIND_XY_TO_D),
        (data_reg.res_x == $past(item_in.res_x)) && (data_reg.res_y == $past(item_in.res_y)))
    // A transfer toward coordinates never writes the index.
    `HCC_ASSERT_NEXT(a_d_kind_keeps_index, aclk, aresetn,
        load && (item_in.kind == hcc_pkg::KIND_D_TO_XY),
        data_reg.res_d == $past(item_in.res_d))

endmodule

// ===== rtl/hilbert_curve_converter.sv =====
// Channel  | Ports                                        | Direction
// ---------+----------------------------------------------+----------
// input    | s_valid s_ready s_kind s_x_coord s_y_coord   | in
//          | s_curve_index                                |
// result   | m_valid m_ready m_index_out m_x_out m_y_out  | out
// config   | cfg_wr_en cfg_wr_data (grid_side_log2)       | in
//
// One transfer is accepted per cycle unless a stall on m_ready has filled the row; each
// result passes through the cells in order, one cell per Hilbert level, finest level in the last cell.
// Each cell is a register stage with its own valid bit, so empty stages keep
// filling while the output waits on m_ready.
// Reset is synchronous and active low; it empties the row and sets grid_side_log2 to 8.
module hilbert_curve_converter #(
    parameter int MAX_LEVELS = hcc_pkg::MAX_LEVELS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [hcc_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [hcc_pkg::COORD_W-1:0]   s_x_coord,
    input  logic [hcc_pkg::COORD_W-1:0]   s_y_coord,
    input  logic [hcc_pkg::INDEX_W-1:0]   s_curve_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [hcc_pkg::INDEX_W-1:0]   m_index_out,
    output logic [hcc_pkg::COORD_W-1:0]   m_x_out,
    output logic [hcc_pkg::COORD_W-1:0]   m_y_out
);

    // Coordinates are 16 bits wide, so no more than 16 levels ever apply.
    localparam int NUM_CELLS = (MAX_LEVELS < hcc_pkg::COORD_W) ? MAX_LEVELS
                                                                : hcc_pkg::COORD_W;
    localparam int LEVEL_W   = hcc_pkg::LEVEL_W;

    logic [hcc_pkg::CFG_W-1:0] grid_side_log2_reg;
    logic [LEVEL_W-1:0]        levels;

    logic                      valid_chain [NUM_CELLS+1];
    logic                      ready_chain [NUM_CELLS+1];
    hcc_pkg::item_t            item_chain  [NUM_CELLS+1];

    // Side register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_side_log2_reg <= hcc_pkg::GRID_LOG2_RESET;
        end else if (cfg_wr_en) begin
            grid_side_log2_reg <= cfg_wr_data;
        end
    end

    // Effective level count, clamped to the number of cells.
    assign levels = (grid_side_log2_reg > LEVEL_W'(NUM_CELLS)) ? LEVEL_W'(NUM_CELLS)
                                                               : grid_side_log2_reg;

    // Fresh items start with no pending rotation and empty results.
    always_comb begin
        item_chain[0]       = '0;
        item_chain[0].kind  = s_kind;
        item_chain[0].src_x = s_x_coord;
        item_chain[0].src_y = s_y_coord;
        item_chain[0].src_d = s_curve_index;
    end

    assign valid_chain[0] = s_valid;
    assign s_ready        = ready_chain[0];

    // Row of cells, coarsest level first.
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        hcc_cell #(
            .LEVEL(NUM_CELLS - 1 - k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .levels    (levels),
            .valid_in  (valid_chain[k]),
            .ready_out (ready_chain[k]),
            .item_in   (item_chain[k]),
            .valid_out (valid_chain[k+1]),
            .ready_in  (ready_chain[k+1]),
            .item_out  (item_chain[k+1])
        );
    end

    // The last cell's register drives the result channel.
    assign ready_chain[NUM_CELLS] = m_ready;
    assign m_valid     = valid_chain[NUM_CELLS];
    assign m_index_out = item_chain[NUM_CELLS].res_d;
    assign m_x_out     = item_chain[NUM_CELLS].res_x;
    assign m_y_out     = item_chain[NUM_CELLS].res_y;

endmodule
